@@ rtl/rcppm_pkg.sv @@
// Shared types, widths and constants of the RC PPM frame decoder.
package rcppm_pkg;

    // Field widths
    localparam int TIME_W     = 16;
    localparam int VAL_W      = 16;
    localparam int CH_W       = 3;
    localparam int CNT_CFG_W  = 4;
    localparam int CFG_IDX_W  = 2;

    // Default channel capacity of a frame
    localparam int MAX_CHANNELS_DEF = 8;

    // Pulse filter limits in ticks
    localparam int WIDTH_MIN    = 1000;
    localparam int WIDTH_MAX    = 2000;
    localparam int WIDTH_CENTER = 1500;
    localparam int THROTTLE_CH  = 2;

    // Mapping datapath: x is 0..1000, span is 17 bit signed
    localparam int X_W     = 10;
    localparam int SPAN_W  = VAL_W + 1;
    localparam int PROD_W  = X_W + 1 + SPAN_W;
    localparam int ABS_W   = 26;
    // floor(n / 1000) == (n * RECIP_MUL) >> RECIP_SHIFT for n < 2**26
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W     = 27;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 27'd68719477;

    // Register reset values
    localparam logic signed [VAL_W-1:0] LOGICAL_LOW_RST  = -16'sd127;
    localparam logic signed [VAL_W-1:0] LOGICAL_HIGH_RST = 16'sd127;
    localparam logic [VAL_W-1:0]        THROTTLE_BIAS_RST = 16'd200;
    localparam logic [CNT_CFG_W-1:0]    CHANNELS_RST      = 4'd6;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOGICAL_LOW,
        REG_LOGICAL_HIGH,
        REG_THROTTLE_BIAS,
        REG_CHANNELS_IN_FRAME
    } t_cfg_idx;

    // Request commands
    typedef enum logic {
        CMD_EDGE,
        CMD_TIMEOUT
    } t_cmd;

endpackage

@@ rtl/rcppm_ifs.sv @@
// Valid/ready channel interfaces of the RC PPM frame decoder.
interface rcppm_cfg_if
    import rcppm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_cfg_idx             index;
    logic [VAL_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

interface rcppm_req_if
    import rcppm_pkg::*;
();
    logic                 valid;
    logic                 ready;
    t_cmd                 cmd;
    logic [TIME_W-1:0]    edge_time;

    modport source (output valid, cmd, edge_time, input ready);
    modport sink   (input valid, cmd, edge_time, output ready);
endinterface

interface rcppm_res_if
    import rcppm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CH_W-1:0]          channel_index;
    logic [TIME_W-1:0]        pulse_width;
    logic signed [VAL_W-1:0]  mapped_value;
    logic                     frame_done;

    modport source (output valid, channel_index, pulse_width, mapped_value, frame_done,
                    input ready);
    modport sink   (input valid, channel_index, pulse_width, mapped_value, frame_done,
                    output ready);
endinterface

@@ rtl/rc_ppm_frame_decoder_unit.sv @@
// RC PPM frame decoder: edge timestamps in, mapped channel values out.
//
// Channels: i_cfg writes the four registers (low, high, throttle bias,
// channels per frame); it is always ready and a write takes effect at once.
// Write it only while no request is in flight. i_req carries edge captures
// (cmd EDGE with the counter value) and sync timeouts (cmd TIMEOUT). o_res
// returns one result per edge after the first edge of a frame: channel index,
// raw wrapped width, mapped value and a frame done flag.
// Throughput: one request per cycle while o_res is not stalled; the pipeline is
// request register, offset-times-span product register and result register,
// with the divide-by-1000 multiply ahead of the result register, each stage
// with its own valid bit, so bubbles are squeezed out.
// Requests that give no result (first edge, timeouts) never enter the pipe.
// Reset (synchronous, active low) restores the register defaults, clears the
// edge count, disarms the timeout and empties the pipeline.
// When the receiver stalls, the result holds and the stages behind it fill;
// i_req.ready drops only once all three stages are occupied.
module rc_ppm_frame_decoder_unit
    import rcppm_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rcppm_cfg_if.sink    i_cfg,
    rcppm_req_if.sink    i_req,
    rcppm_res_if.source  o_res
);

    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam int CMP_W = 5;
    localparam int QP_W  = ABS_W + RECIP_W;
    localparam int Q_W   = QP_W - RECIP_SHIFT;
    localparam int SUM_W = Q_W + 1;

    // Configuration registers
    logic signed [VAL_W-1:0]  r_logical_low;
    logic signed [VAL_W-1:0]  r_logical_high;
    logic [VAL_W-1:0]         r_throttle_bias;
    logic [CNT_CFG_W-1:0]     r_channels;

    // Frame state
    logic [CNT_W-1:0]         r_edge_count, n_edge_count;
    logic [TIME_W-1:0]        r_prev_edge, n_prev_edge;
    logic                     r_armed, n_armed;

    // Pipeline registers
    logic                     r_s1_valid;
    logic [CH_W-1:0]          r_s1_ch;
    logic [TIME_W-1:0]        r_s1_width;
    logic [X_W-1:0]           r_s1_x;
    logic                     r_s1_done;

    logic                     r_s2_valid;
    logic [CH_W-1:0]          r_s2_ch;
    logic [TIME_W-1:0]        r_s2_width;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic                     r_s2_done;

    logic                     r_out_valid;
    logic [CH_W-1:0]          r_out_ch;
    logic [TIME_W-1:0]        r_out_width;
    logic signed [VAL_W-1:0]  r_out_mapped;
    logic                     r_out_done;

    // Handshake and front-end logic
    logic                     w_out_ready, w_s2_ready, w_s1_ready;
    logic                     w_acc, w_is_edge, w_first, w_result;
    logic [TIME_W-1:0]        w_width, w_filt;
    logic [CNT_W-1:0]         w_ch;
    logic                     w_throttle, w_in_range, w_done;
    logic [X_W-1:0]           w_x;
    logic [CMP_W-1:0]         w_nch;
    logic signed [SPAN_W-1:0] w_span;
    logic [ABS_W-1:0]         w_abs;
    logic [QP_W-1:0]          w_qprod;
    logic [Q_W-1:0]           w_q;
    logic signed [SUM_W-1:0]  w_sum;

    // Stage readiness, backward from the result register
    assign w_out_ready = !r_out_valid || o_res.ready;
    assign w_s2_ready  = !r_s2_valid || w_out_ready;
    assign w_s1_ready  = !r_s1_valid || w_s2_ready;

    assign i_req.ready = w_s1_ready;
    assign i_cfg.ready = 1'b1;
    assign w_acc       = i_req.valid && w_s1_ready;

    // Width, throttle bias and range filter
    assign w_is_edge  = (i_req.cmd == CMD_EDGE);
    assign w_first    = (r_edge_count == '0);
    assign w_result   = w_acc && w_is_edge && !w_first;
    assign w_width    = i_req.edge_time - r_prev_edge;
    assign w_ch       = r_edge_count - CNT_W'(1);
    assign w_throttle = (CMP_W'(r_edge_count) == CMP_W'(THROTTLE_CH + 1));
    assign w_filt     = w_throttle ? (w_width + r_throttle_bias) : w_width;
    assign w_in_range = (w_filt >= TIME_W'(WIDTH_MIN)) && (w_filt <= TIME_W'(WIDTH_MAX));
    assign w_x        = w_in_range ? X_W'(w_filt - TIME_W'(WIDTH_MIN))
                                   : X_W'(WIDTH_CENTER - WIDTH_MIN);

    // Channel count clamped to 1..MAX_CHANNELS
    always_comb begin
        priority if (r_channels == '0) begin
            w_nch = CMP_W'(1);
        end else if (CMP_W'(r_channels) > CMP_W'(MAX_CHANNELS)) begin
            w_nch = CMP_W'(MAX_CHANNELS);
        end else begin
            w_nch = CMP_W'(r_channels);
        end
    end

    // Edge that completes the frame
    assign w_done = (CMP_W'(r_edge_count) >= w_nch);

    // Next frame state
    always_comb begin
        n_edge_count = r_edge_count;
        n_prev_edge  = r_prev_edge;
        n_armed      = r_armed;
        if (w_acc) begin
            unique case (i_req.cmd)
                CMD_TIMEOUT: begin
                    if (r_armed) begin
                        n_edge_count = '0;
                        n_armed      = 1'b0;
                    end
                end
                CMD_EDGE: begin
                    n_prev_edge = i_req.edge_time;
                    if (w_first) begin
                        n_edge_count = CNT_W'(1);
                        n_armed      = 1'b1;
                    end else begin
                        n_edge_count = w_done ? '0 : (r_edge_count + CNT_W'(1));
                    end
                end
                default: begin
                    n_edge_count = r_edge_count;
                end
            endcase
        end
    end

    // Configuration writes and frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_logical_low   <= LOGICAL_LOW_RST;
            r_logical_high  <= LOGICAL_HIGH_RST;
            r_throttle_bias <= THROTTLE_BIAS_RST;
            r_channels      <= CHANNELS_RST;
            r_edge_count    <= '0;
            r_prev_edge     <= '0;
            r_armed         <= 1'b0;
        end else begin
            r_edge_count <= n_edge_count;
            r_prev_edge  <= n_prev_edge;
            r_armed      <= n_armed;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_LOGICAL_LOW:       r_logical_low   <= i_cfg.data;
                    REG_LOGICAL_HIGH:      r_logical_high  <= i_cfg.data;
                    REG_THROTTLE_BIAS:     r_throttle_bias <= i_cfg.data;
                    REG_CHANNELS_IN_FRAME: r_channels      <= i_cfg.data[CNT_CFG_W-1:0];
                    default:               r_channels      <= r_channels;
                endcase
            end
        end
    end

    // Stage 1: request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_ready) begin
            r_s1_valid <= w_result;
        end
        if (w_s1_ready && w_result) begin
            r_s1_ch    <= CH_W'(w_ch);
            r_s1_width <= w_width;
            r_s1_x     <= w_x;
            r_s1_done  <= w_done;
        end
    end

    // Stage 2: offset times span
    assign w_span = $signed({r_logical_high[VAL_W-1], r_logical_high})
                  - $signed({r_logical_low[VAL_W-1], r_logical_low});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (w_s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
        if (w_s2_ready && r_s1_valid) begin
            r_s2_ch    <= r_s1_ch;
            r_s2_width <= r_s1_width;
            r_s2_prod  <= PROD_W'($signed({1'b0, r_s1_x})) * PROD_W'(w_span);
            r_s2_done  <= r_s1_done;
        end
    end

    // Stage 3: truncating divide by 1000 via reciprocal, then add low
    assign w_abs   = r_s2_prod[PROD_W-1] ? ABS_W'(-r_s2_prod) : ABS_W'(r_s2_prod);
    assign w_qprod = QP_W'(w_abs) * QP_W'(RECIP_MUL);
    assign w_q     = w_qprod[QP_W-1:RECIP_SHIFT];
    assign w_sum   = (r_s2_prod[PROD_W-1] ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q}))
                   + SUM_W'(r_logical_low);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_out_valid <= r_s2_valid;
        end
        if (w_out_ready && r_s2_valid) begin
            r_out_ch     <= r_s2_ch;
            r_out_width  <= r_s2_width;
            r_out_mapped <= w_sum[VAL_W-1:0];
            r_out_done   <= r_s2_done;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.channel_index = r_out_ch;
    assign o_res.pulse_width   = r_out_width;
    assign o_res.mapped_value  = r_out_mapped;
    assign o_res.frame_done    = r_out_done;

endmodule

@@ rtl/rcppm_checker.sv @@
// Port-level assertions of the RC PPM frame decoder, bound to the top level.
module rcppm_checker
    import rcppm_pkg::*;
(
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_cfg_valid,
    input logic                    i_cfg_ready,
    input t_cfg_idx                i_cfg_index,
    input logic [VAL_W-1:0]        i_cfg_data,
    input logic                    i_res_valid,
    input logic                    i_res_ready,
    input logic [CH_W-1:0]         i_res_ch,
    input logic [TIME_W-1:0]       i_res_width,
    input logic signed [VAL_W-1:0] i_res_mapped,
    input logic                    i_res_done
);

    logic                    r_after_done;
    logic [CH_W-1:0]         r_prev_ch;
    logic signed [VAL_W-1:0] r_low, r_high;
    logic signed [VAL_W-1:0] w_min, w_max;
    logic                    w_res_acc;

    assign w_res_acc = i_res_valid && i_res_ready;
    assign w_min     = (r_low < r_high) ? r_low : r_high;
    assign w_max     = (r_low < r_high) ? r_high : r_low;

    // Shadow of the logical range and of the last delivered channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_done <= 1'b1;
            r_prev_ch    <= '0;
            r_low        <= LOGICAL_LOW_RST;
            r_high       <= LOGICAL_HIGH_RST;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index == REG_LOGICAL_LOW) begin
                r_low <= i_cfg_data;
            end
            if (i_cfg_valid && i_cfg_ready && i_cfg_index == REG_LOGICAL_HIGH) begin
                r_high <= i_cfg_data;
            end
            if (w_res_acc) begin
                r_after_done <= i_res_done;
                r_prev_ch    <= i_res_ch;
            end
        end
    end

    // Stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_width)
            && $stable(i_res_mapped) && $stable(i_res_ch) && $stable(i_res_done))
        else $error("result changed while stalled");

    // A frame always restarts at channel zero
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_acc && r_after_done |-> i_res_ch == '0)
        else $error("frame did not start at channel zero");

    // Within a frame channels advance by one, or restart after a timeout
    a_ch_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_acc && !r_after_done |-> i_res_ch == r_prev_ch + CH_W'(1) || i_res_ch == '0)
        else $error("channel index skipped");

    // Mapped value stays inside the logical range
    a_map_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_acc |-> i_res_mapped >= w_min && i_res_mapped <= w_max)
        else $error("mapped value out of range");

endmodule

bind rc_ppm_frame_decoder_unit rcppm_checker u_rcppm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_cfg_index  (i_cfg.index),
    .i_cfg_data   (i_cfg.data),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_ch     (o_res.channel_index),
    .i_res_width  (o_res.pulse_width),
    .i_res_mapped (o_res.mapped_value),
    .i_res_done   (o_res.frame_done)
);

@@ test/rc_ppm_frame_decoder_unit_tb.sv @@
// Self-checking testbench of the RC PPM frame decoder: directed frames, then random traffic.
module rc_ppm_frame_decoder_unit_tb;
    import rcppm_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int IDLE_SETTLE  = 6;
    localparam int PHASE_ITEMS  = 240;
    localparam int RANDOM_PHASES = 6;

    // One expected pulse result
    typedef struct packed {
        logic [CH_W-1:0]         chan;
        logic [TIME_W-1:0]       width;
        logic signed [VAL_W-1:0] value;
        logic                    done;
    } t_pulse_result;

    logic i_clk;
    logic i_rst_n;

    rcppm_cfg_if cfg_if ();
    rcppm_req_if req_if ();
    rcppm_res_if res_if ();

    rc_ppm_frame_decoder_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    // Decoder state and registers as the testbench sees them
    logic signed [VAL_W-1:0] cfg_low;
    logic signed [VAL_W-1:0] cfg_high;
    logic [VAL_W-1:0]        cfg_bias;
    logic [CNT_CFG_W-1:0]    cfg_chans;
    int                      edge_count;
    logic [TIME_W-1:0]       last_edge;
    logic                    armed;

    t_pulse_result pending_pulses[$];
    t_pulse_result sink_want;
    int            mismatch_count;
    int            requests_sent;
    int            cycle_count;
    int            stall_left;
    bit            req_calm;
    bit            sink_calm;
    logic [TIME_W-1:0] stamp;

    always #1 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void reset_model();
        cfg_low    = LOGICAL_LOW_RST;
        cfg_high   = LOGICAL_HIGH_RST;
        cfg_bias   = THROTTLE_BIAS_RST;
        cfg_chans  = CHANNELS_RST;
        edge_count = 0;
        last_edge  = '0;
        armed      = 1'b0;
    endfunction

    // Channel count clamped to 1..MAX_CHANNELS
    function automatic int channels_per_frame();
        int n;
        n = int'(cfg_chans);
        if (n < 1) n = 1;
        if (n > MAX_CHANNELS_DEF) n = MAX_CHANNELS_DEF;
        return n;
    endfunction

    // Filter to 1000..2000 (else center), then scale onto low..high
    function automatic logic [VAL_W-1:0] map_width(input logic [TIME_W-1:0] w);
        longint x;
        longint span;
        longint r;
        if (w < WIDTH_MIN || w > WIDTH_MAX) w = TIME_W'(WIDTH_CENTER);
        x    = longint'(w);
        x    = x - WIDTH_MIN;
        span = longint'(cfg_high) - longint'(cfg_low);
        r    = x * span / (WIDTH_MAX - WIDTH_MIN) + longint'(cfg_low);
        return r[VAL_W-1:0];
    endfunction

    // Advance the decoder state by one accepted request
    function automatic void decode_request(input t_cmd c, input logic [TIME_W-1:0] t);
        int            ch;
        logic [TIME_W-1:0] width;
        logic [TIME_W-1:0] filt;
        t_pulse_result res;
        if (c == CMD_TIMEOUT) begin
            if (armed) begin
                edge_count = 0;
                armed      = 1'b0;
            end
            return;
        end
        if (edge_count == 0) begin
            edge_count = 1;
            last_edge  = t;
            armed      = 1'b1;
            return;
        end
        ch         = edge_count - 1;
        edge_count = edge_count + 1;
        width      = t - last_edge;
        last_edge  = t;
        filt       = (ch == THROTTLE_CH) ? width + cfg_bias : width;
        res.chan   = ch[CH_W-1:0];
        res.width  = width;
        res.value  = map_width(filt);
        res.done   = (edge_count >= channels_per_frame() + 1);
        if (res.done) edge_count = 0;
        pending_pulses.push_back(res);
    endfunction

    // Send one request; valid stays high on return so back-to-back needs no toggle
    task automatic send_req(input t_cmd c, input logic [TIME_W-1:0] t);
        int gap;
        if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
        gap = req_calm ? 0 : pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.cmd       <= c;
        req_if.edge_time <= t;
        do @(posedge i_clk); while (!req_if.ready);
        decode_request(c, t);
        requests_sent++;
    endtask

    task automatic send_width(input logic [TIME_W-1:0] w);
        stamp = stamp + w;
        send_req(CMD_EDGE, stamp);
    endtask

    // Drop valid and let the pipeline drain before touching registers
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_pulses.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [VAL_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            REG_LOGICAL_LOW:       cfg_low   = value;
            REG_LOGICAL_HIGH:      cfg_high  = value;
            REG_THROTTLE_BIAS:     cfg_bias  = value;
            REG_CHANNELS_IN_FRAME: cfg_chans = value[CNT_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // Reset registers: filter edges, throttle bias, wrap of the counter
    task automatic test_default_frame();
        send_req(CMD_TIMEOUT, 16'h1234);    // disarmed: ignored
        stamp = 16'hFC00;
        send_req(CMD_EDGE, stamp);
        send_width(16'd1000);
        send_width(16'd2000);
        send_width(16'd1300);               // throttle: 1300 + 200
        send_width(16'd999);
        send_width(16'd2001);
        send_width(16'd1750);               // frame done
    endtask

    // Timeout after a completed frame, mid-frame, and while disarmed
    task automatic test_sync_timeout();
        send_req(CMD_TIMEOUT, 16'hFFFF);
        stamp = 16'h0000;
        send_req(CMD_EDGE, stamp);
        send_width(16'd0);
        send_width(16'hFFFF);
        send_req(CMD_TIMEOUT, 16'h0000);
        send_req(CMD_TIMEOUT, 16'h5A5A);
        send_req(CMD_EDGE, stamp);
        send_width(16'd1234);
    endtask

    // Full-scale and inverted ranges, bias wrap, channel count zero and saturated
    task automatic test_config_extremes();
        wait_idle();
        write_reg(REG_LOGICAL_LOW, 16'h8000);
        write_reg(REG_LOGICAL_HIGH, 16'h7FFF);
        write_reg(REG_THROTTLE_BIAS, 16'hFFFF);
        write_reg(REG_CHANNELS_IN_FRAME, 16'h0000);
        send_req(CMD_TIMEOUT, 16'h0F0F);
        stamp = 16'h8000;
        send_req(CMD_EDGE, stamp);
        send_width(16'd2000);               // one-channel frame
        wait_idle();
        write_reg(REG_LOGICAL_LOW, 16'h7FFF);
        write_reg(REG_LOGICAL_HIGH, 16'h8000);
        write_reg(REG_CHANNELS_IN_FRAME, 16'hFFFF);
        send_req(CMD_EDGE, stamp);
        send_width(16'd1000);
        send_width(16'd2000);
        send_width(16'd1601);               // throttle: bias wraps to -1
        send_width(16'd1250);
        send_width(16'd2100);
        send_width(16'd500);
        send_width(16'd1999);
        send_width(16'd1001);               // eighth channel ends frame
    endtask

    // Channel count lowered below the edges already seen
    task automatic test_shrink_frame();
        wait_idle();
        write_reg(REG_CHANNELS_IN_FRAME, 16'd8);
        send_req(CMD_TIMEOUT, 16'h0000);
        send_req(CMD_EDGE, stamp);
        send_width(16'd1100);
        send_width(16'd1200);
        send_width(16'd1300);
        wait_idle();
        write_reg(REG_CHANNELS_IN_FRAME, 16'd2);
        send_width(16'd1400);               // ends the frame at once
    endtask

    function automatic logic [TIME_W-1:0] random_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return TIME_W'($urandom_range(950, 2050));
        if (r < 80) begin
            case ($urandom_range(0, 4))
                0: return 16'd1000;
                1: return 16'd2000;
                2: return 16'd999;
                3: return 16'd2001;
                default: return 16'd1500;
            endcase
        end
        return TIME_W'($urandom);
    endfunction

    task automatic randomize_regs();
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        case ($urandom_range(0, 3))
            0: begin lo = VAL_W'($urandom); hi = VAL_W'($urandom); end
            1: begin
                lo = VAL_W'(-$urandom_range(0, 1000));
                hi = VAL_W'($urandom_range(0, 1000));
            end
            2: begin
                lo = VAL_W'($urandom_range(0, 1000));
                hi = VAL_W'(-$urandom_range(0, 1000));
            end
            default: begin lo = VAL_W'($urandom); hi = lo; end
        endcase
        wait_idle();
        write_reg(REG_LOGICAL_LOW, lo);
        write_reg(REG_LOGICAL_HIGH, hi);
        write_reg(REG_THROTTLE_BIAS,
                  ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 600)) : 16'($urandom));
        write_reg(REG_CHANNELS_IN_FRAME, 16'($urandom));
    endtask

    // Mostly well-formed frames with random widths, some cut short, some noise
    task automatic test_random_traffic();
        int target;
        int len;
        bit broken;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            randomize_regs();
            target = requests_sent + PHASE_ITEMS;
            while (requests_sent < target) begin
                if ($urandom_range(0, 99) < 80) begin
                    if ($urandom_range(0, 3) != 0) send_req(CMD_TIMEOUT, 16'($urandom));
                    stamp = TIME_W'($urandom);
                    send_req(CMD_EDGE, stamp);
                    len    = channels_per_frame();
                    broken = ($urandom_range(0, 9) == 0);
                    if (broken) len = $urandom_range(0, len);
                    for (int i = 0; i < len; i++) send_width(random_width());
                    if (broken) send_req(CMD_TIMEOUT, 16'($urandom));
                end else begin
                    send_req(t_cmd'($urandom_range(0, 1)), 16'($urandom));
                end
            end
        end
    endtask

    // Result sink: random stalls, compare each accepted result in order
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_pulses.size() == 0) begin
                $error("unexpected result: channel_index %0d pulse_width %0d",
                       res_if.channel_index, res_if.pulse_width);
                mismatch_count++;
            end else begin
                sink_want = pending_pulses.pop_front();
                if (res_if.channel_index !== sink_want.chan) begin
                    $error("channel_index: expected %0d, got %0d",
                           sink_want.chan, res_if.channel_index);
                    mismatch_count++;
                end
                if (res_if.pulse_width !== sink_want.width) begin
                    $error("pulse_width: expected %0d, got %0d",
                           sink_want.width, res_if.pulse_width);
                    mismatch_count++;
                end
                if (res_if.mapped_value !== sink_want.value) begin
                    $error("mapped_value: expected %0d, got %0d",
                           $signed(sink_want.value), $signed(res_if.mapped_value));
                    mismatch_count++;
                end
                if (res_if.frame_done !== sink_want.done) begin
                    $error("frame_done: expected %0d, got %0d",
                           sink_want.done, res_if.frame_done);
                    mismatch_count++;
                end
            end
        end
        if ($urandom_range(0, 63) == 0) sink_calm = !sink_calm;
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else begin
            res_if.ready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = REG_LOGICAL_LOW;
        cfg_if.data      = '0;
        req_if.valid     = 1'b0;
        req_if.cmd       = CMD_EDGE;
        req_if.edge_time = '0;
        res_if.ready     = 1'b0;
        mismatch_count   = 0;
        requests_sent    = 0;
        cycle_count      = 0;
        stall_left       = 0;
        req_calm         = 1'b0;
        sink_calm        = 1'b0;
        stamp            = '0;
        reset_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_frame();
        test_sync_timeout();
        test_config_extremes();
        test_shrink_frame();
        test_random_traffic();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/rcppm_pkg.sv
rtl/rcppm_ifs.sv
rtl/rc_ppm_frame_decoder_unit.sv
rtl/rcppm_checker.sv
test/rc_ppm_frame_decoder_unit_tb.sv
